FILE: hw/rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants for the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  // Default sizing
  localparam int LEAF_COUNT_DEF = 1024;
  localparam int VALUE_BITS_DEF = 31;

  // Fixed field widths
  localparam int IDX_W  = 11;
  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Opcodes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

endpackage

FILE: hw/rtl/rmst_mem.sv
// ----------------------------------------------------------------------------
// rmst_mem
// Tree node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rmst_mem #(
  parameter int DEPTH = 4096,
  parameter int DW    = 31
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for clearing, point updates and range-minimum queries.
// ----------------------------------------------------------------------------
module rmst_ctrl #(
  parameter int LEAF_COUNT = 1024,
  parameter int VALUE_BITS = 31,
  localparam int DEPTH = 4 * LEAF_COUNT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic [rmst_pkg::IDX_W-1:0] in_first_index,
  input  logic [rmst_pkg::IDX_W-1:0] in_second_index,
  input  logic [VALUE_BITS-1:0]     in_new_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [VALUE_BITS-1:0]     out_min_value,
  output logic                      out_found,
  input  logic                      cfg_we,
  input  logic [rmst_pkg::SIZE_W-1:0] cfg_wdata,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [VALUE_BITS-1:0]     wr_data,
  output logic [AW-1:0]             rd_addr,
  input  logic [VALUE_BITS-1:0]     rd_data_r
);

  localparam int PW0 = $clog2(LEAF_COUNT + 1);
  localparam int PW  = (PW0 > rmst_pkg::IDX_W) ? PW0 : rmst_pkg::IDX_W;
  localparam int SD  = $clog2(LEAF_COUNT) + 2;
  localparam int SIW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QVIS  = 3'd2;
  localparam logic [2:0] ST_QWAIT = 3'd3;
  localparam logic [2:0] ST_QDONE = 3'd4;
  localparam logic [2:0] ST_UDN   = 3'd5;
  localparam logic [2:0] ST_UWAIT = 3'd6;

  localparam logic [AW-1:0] ROOT = AW'(1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  logic [2:0]            st_r, st_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [rmst_pkg::SIZE_W-1:0] size_r;
  logic [AW-1:0]         node_r, node_nxt;
  logic [PW-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [PW-1:0]         a_r, a_nxt, b_r, b_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt, acc_r, acc_nxt;
  logic                  fnd_r, fnd_nxt;
  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [AW-1:0]         stk_node_r [SD];
  logic [PW-1:0]         stk_lo_r [SD];
  logic [PW-1:0]         stk_hi_r [SD];
  logic                  push;
  logic [AW-1:0]         push_node;
  logic [PW-1:0]         push_lo, push_hi;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_min_r, out_min_nxt;
  logic                  out_found_r, out_found_nxt;

  logic [PW-1:0]         n_eff, in_a, in_b;
  logic [PW:0]           sum;
  logic [PW-1:0]         mid;
  logic [SPW-1:0]        sp_m1;
  logic [AW-1:0]         child_l, parent;
  logic [VALUE_BITS-1:0] up_min;

  // Clamp the configured count to the tree size
  always_comb begin
    if (PW'(size_r) > PW'(LEAF_COUNT)) begin
      n_eff = PW'(LEAF_COUNT);
    end else begin
      n_eff = PW'(size_r);
    end
  end

  assign in_a    = PW'(in_first_index);
  assign in_b    = PW'(in_second_index);
  assign sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = sum[PW:1];
  assign sp_m1   = sp_r - SPW'(1);
  assign child_l = {node_r[AW-2:0], 1'b0};
  assign parent  = node_r >> 1;
  assign up_min  = (rd_data_r < val_r) ? rd_data_r : val_r;

  assign in_ready      = (st_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_found     = out_found_r;

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    fnd_nxt       = fnd_r;
    sp_nxt        = sp_r;
    push          = 1'b0;
    push_node     = child_l | ROOT;
    push_lo       = mid + PW'(1);
    push_hi       = hi_r;
    wr_en         = 1'b0;
    wr_addr       = node_r;
    wr_data       = val_r;
    rd_addr       = node_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_min_nxt   = out_min_r;
    out_found_nxt = out_found_r;

    unique case (st_r)
      // Sweep the store to the maximum value
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = VMAX;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST) begin
          st_nxt = ST_IDLE;
        end
      end
      // Take a request
      ST_IDLE: begin
        if (in_valid) begin
          node_nxt = ROOT;
          lo_nxt   = PW'(1);
          hi_nxt   = n_eff;
          a_nxt    = in_a;
          b_nxt    = in_b;
          val_nxt  = in_new_value;
          fnd_nxt  = 1'b0;
          sp_nxt   = '0;
          if (in_opcode == rmst_pkg::OP_QUERY) begin
            if (n_eff == '0 || in_a > in_b) begin
              st_nxt = ST_QDONE;
            end else begin
              st_nxt = ST_QVIS;
            end
          end else if (n_eff != '0 && in_a != '0 && in_a <= n_eff) begin
            st_nxt = ST_UDN;
          end
        end
      end
      // Visit one node of the query walk
      ST_QVIS: begin
        if (b_r < lo_r || a_r > hi_r) begin
          if (sp_r == '0) begin
            st_nxt = ST_QDONE;
          end else begin
            node_nxt = stk_node_r[sp_m1[SIW-1:0]];
            lo_nxt   = stk_lo_r[sp_m1[SIW-1:0]];
            hi_nxt   = stk_hi_r[sp_m1[SIW-1:0]];
            sp_nxt   = sp_m1;
          end
        end else if (a_r <= lo_r && b_r >= hi_r) begin
          st_nxt = ST_QWAIT;
        end else begin
          push     = 1'b1;
          sp_nxt   = sp_r + SPW'(1);
          node_nxt = child_l;
          hi_nxt   = mid;
        end
      end
      // Fold the node value, then pop
      ST_QWAIT: begin
        acc_nxt = (fnd_r && acc_r < rd_data_r) ? acc_r : rd_data_r;
        fnd_nxt = 1'b1;
        if (sp_r == '0) begin
          st_nxt = ST_QDONE;
        end else begin
          node_nxt = stk_node_r[sp_m1[SIW-1:0]];
          lo_nxt   = stk_lo_r[sp_m1[SIW-1:0]];
          hi_nxt   = stk_hi_r[sp_m1[SIW-1:0]];
          sp_nxt   = sp_m1;
          st_nxt   = ST_QVIS;
        end
      end
      // Hand the result to the output register
      ST_QDONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = fnd_r ? acc_r : '0;
          out_found_nxt = fnd_r;
          st_nxt        = ST_IDLE;
        end
      end
      // Descend to the leaf, then write it
      ST_UDN: begin
        if (lo_r == hi_r) begin
          wr_en = 1'b1;
          if (node_r == ROOT) begin
            st_nxt = ST_IDLE;
          end else begin
            rd_addr = node_r ^ ROOT;
            st_nxt  = ST_UWAIT;
          end
        end else if (a_r <= mid) begin
          node_nxt = child_l;
          hi_nxt   = mid;
        end else begin
          node_nxt = child_l | ROOT;
          lo_nxt   = mid + PW'(1);
        end
      end
      // Climb: parent gets min of carried value and sibling
      ST_UWAIT: begin
        wr_en    = 1'b1;
        wr_addr  = parent;
        wr_data  = up_min;
        val_nxt  = up_min;
        node_nxt = parent;
        rd_addr  = parent ^ ROOT;
        if (parent == ROOT) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      size_r      <= rmst_pkg::SIZE_RESET;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  // Payload and walk stack
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    val_r       <= val_nxt;
    acc_r       <= acc_nxt;
    fnd_r       <= fnd_nxt;
    out_min_r   <= out_min_nxt;
    out_found_r <= out_found_nxt;
    if (push) begin
      stk_node_r[sp_r[SIW-1:0]] <= push_node;
      stk_lo_r[sp_r[SIW-1:0]]   <= push_lo;
      stk_hi_r[sp_r[SIW-1:0]]   <= push_hi;
    end
  end

endmodule

FILE: hw/rtl/range_min_segment_tree.sv
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Segment tree for point updates and range-minimum queries over 1..n.
// ----------------------------------------------------------------------------
// After reset the block sweeps its node store to the maximum value, one entry
// a cycle, over all 4*LEAF_COUNT entries (4096 by default) with in_ready low.
// An update then walks down to the leaf of its index (at depth 10 for
// n = 1024), writes it, and climbs back to the root, writing each parent with
// the minimum of the carried value and the sibling, which is read through the
// single read port of the store. A query walks the tree with a stack, reads
// each node that lies wholly in the range and folds it into the minimum, then
// loads the result register.
// One request is in work at a time; the result register frees the input side.
module range_min_segment_tree #(
  parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF,
  parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [rmst_pkg::IDX_W-1:0]  in_first_index,
  input  logic [rmst_pkg::IDX_W-1:0]  in_second_index,
  input  logic [VALUE_BITS-1:0]       in_new_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [VALUE_BITS-1:0]       out_min_value,
  output logic                        out_found,
  input  logic                        cfg_we,
  input  logic [rmst_pkg::SIZE_W-1:0] cfg_wdata
);

  localparam int DEPTH = 4 * LEAF_COUNT;
  localparam int AW    = $clog2(DEPTH);

  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] wr_data, rd_data_r;

  rmst_ctrl #(
    .LEAF_COUNT (LEAF_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_value   (out_min_value),
    .out_found       (out_found),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr         (rd_addr),
    .rd_data_r       (rd_data_r)
  );

  rmst_mem #(
    .DEPTH (DEPTH),
    .DW    (VALUE_BITS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

endmodule

FILE: hw/rtl/rmst_checker.sv
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks for the range-minimum segment tree.
// ----------------------------------------------------------------------------
module rmst_checker #(
  parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_opcode,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_min_value,
  input logic                  out_found
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_value) && $stable(out_found))
    else $error("stalled result changed");

  // Report zero when nothing found
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_min_value == '0)
    else $error("empty result carries a value");

  // Drop ready after taking a query request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == rmst_pkg::OP_QUERY |=> !in_ready)
    else $error("second request taken while busy");

  // Result follows only a taken request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind range_min_segment_tree rmst_checker #(.VALUE_BITS(VALUE_BITS)) u_rmst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_opcode     (in_opcode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_min_value (out_min_value),
  .out_found     (out_found)
);
